// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the sum segment tree block.
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int CMD_W   = 1;
   localparam int POS_W   = 4;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   localparam logic [CMD_W-1:0]   CMD_WRITE = 1'b0;
   localparam logic [CMD_W-1:0]   CMD_QUERY = 1'b1;

   localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DESCEND,
      ST_UP_READ,
      ST_UP_WRITE,
      ST_QUERY,
      ST_DRAIN,
      ST_RESULT
   } sst_state_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] range_sum;
      logic                      index_error;
   } sst_rsp_type;

endpackage

// ===== rtl/sst_if.sv =====
// ----------------------------------------------------------------------------
// sst_if
// Valid/ready channel interfaces for commands and results.
// ----------------------------------------------------------------------------
interface sst_req_if
   import sst_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic [POS_W-1:0]          position;
   logic [POS_W-1:0]          range_end;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, cmd, position, range_end, value, input ready);
   modport sink   (input valid, cmd, position, range_end, value, output ready);
endinterface

interface sst_rsp_if
   import sst_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] range_sum;
   logic                      index_error;

   modport source (output valid, range_sum, index_error, input ready);
   modport sink   (input valid, range_sum, index_error, output ready);
endinterface

// ===== rtl/sst_node_ram.sv =====
// ----------------------------------------------------------------------------
// sst_node_ram
// Simple dual-port node store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sst_node_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sst_engine.sv =====
// ----------------------------------------------------------------------------
// sst_engine
// Tree walker: clearing sweep, leaf update with ancestor rebuild, and
// range-sum query over the node store.
// ----------------------------------------------------------------------------
module sst_engine
   import sst_pkg::*;
#(
   parameter int NODE_COUNT   = 64,
   parameter int DATA_WIDTH   = 32,
   parameter int IW           = 5,
   parameter int NW           = 7,
   parameter int AW           = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear_start,
   input  logic [IW-1:0]         used_count,
   sst_req_if.sink               req,
   output logic                  res_valid,
   input  logic                  res_ready,
   output sst_rsp_type           res,
   output logic                  mem_wr_en,
   output logic [AW-1:0]         mem_wr_addr,
   output logic [DATA_WIDTH-1:0] mem_wr_data,
   output logic                  mem_rd_en,
   output logic [AW-1:0]         mem_rd_addr,
   input  logic [DATA_WIDTH-1:0] mem_rd_data
);

   localparam logic [NW-1:0] NODE_LIMIT = NW'(NODE_COUNT);
   localparam logic [AW-1:0] LAST_ADDR  = AW'(NODE_COUNT - 1);

   function automatic logic in_store(input logic [NW-1:0] n);
      return n < NODE_LIMIT;
   endfunction

   sst_state_type         state_ff, state_in;
   logic [NW-1:0]         node_ff, node_in;
   logic [IW-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [NW-1:0]         sv_node_ff, sv_node_in;
   logic [IW-1:0]         sv_lo_ff, sv_lo_in, sv_hi_ff, sv_hi_in;
   logic                  sv_valid_ff, sv_valid_in;
   logic [IW-1:0]         pos_ff, pos_in, rend_ff, rend_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [DATA_WIDTH-1:0] cur_ff, cur_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic                  pend_ff, pend_in;
   logic                  sib_ff, sib_in;
   logic                  err_ff, err_in;
   logic [AW-1:0]         clr_cnt_ff, clr_cnt_in;

   logic                  accept;
   logic [IW-1:0]         req_pos, req_end, mid;
   logic                  bad_pos, bad_end, req_err, req_empty;
   logic [NW-1:0]         left_node, right_node, sib_node, parent_node;
   logic                  is_leaf, full, go_l, go_r, path_done;
   logic [DATA_WIDTH-1:0] parent_sum;

   assign req_pos   = IW'(req.position);
   assign req_end   = IW'(req.range_end);
   assign bad_pos   = req_pos >= used_count;
   assign bad_end   = req_end >= used_count;
   assign req_err   = bad_pos || (req.cmd == CMD_QUERY && bad_end);
   assign req_empty = req.cmd == CMD_QUERY && req_pos > req_end;
   assign req.ready = state_ff == ST_IDLE;
   assign accept    = req.valid && req.ready;

   assign mid         = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign left_node   = (node_ff << 1) + NW'(1);
   assign right_node  = (node_ff << 1) + NW'(2);
   assign sib_node    = node_ff[0] ? node_ff + NW'(1) : node_ff - NW'(1);
   assign parent_node = (node_ff - NW'(1)) >> 1;
   assign parent_sum  = cur_ff + (sib_ff ? mem_rd_data : '0);

   assign is_leaf   = lo_ff == hi_ff;
   assign full      = pos_ff <= lo_ff && rend_ff >= hi_ff;
   assign go_l      = pos_ff <= mid;
   assign go_r      = rend_ff > mid;
   assign path_done = full && !sv_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_err || req_empty)     state_in = ST_RESULT;
               else if (req.cmd == CMD_WRITE) state_in = ST_DESCEND;
               else                           state_in = ST_QUERY;
            end
         end
         ST_DESCEND: begin
            if (is_leaf) state_in = (node_ff == '0) ? ST_RESULT : ST_UP_READ;
         end
         ST_UP_READ:  state_in = ST_UP_WRITE;
         ST_UP_WRITE: state_in = (parent_node == '0) ? ST_RESULT : ST_UP_READ;
         ST_QUERY: begin
            if (path_done) state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_RESULT;
         ST_RESULT: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
      if (clear_start) state_in = ST_CLEAR;
   end

   // datapath and memory control
   always_comb begin
      node_in     = node_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      sv_node_in  = sv_node_ff;
      sv_lo_in    = sv_lo_ff;
      sv_hi_in    = sv_hi_ff;
      sv_valid_in = sv_valid_ff;
      pos_in      = pos_ff;
      rend_in     = rend_ff;
      value_in    = value_ff;
      cur_in      = cur_ff;
      err_in      = err_ff;
      sib_in      = 1'b0;
      pend_in     = 1'b0;
      acc_in      = pend_ff ? acc_ff + mem_rd_data : acc_ff;
      clr_cnt_in  = clr_cnt_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = node_ff[AW-1:0];
      mem_wr_data = value_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = node_ff[AW-1:0];
      res_valid   = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               node_in     = '0;
               lo_in       = '0;
               hi_in       = used_count - IW'(1);
               pos_in      = req_pos;
               rend_in     = req_end;
               value_in    = DATA_WIDTH'(req.value);
               err_in      = req_err;
               acc_in      = '0;
               sv_valid_in = 1'b0;
            end
         end
         ST_DESCEND: begin
            if (is_leaf) begin
               mem_wr_en = in_store(node_ff);
               cur_in    = in_store(node_ff) ? value_ff : '0;
            end else if (pos_ff <= mid) begin
               node_in = left_node;
               hi_in   = mid;
            end else begin
               node_in = right_node;
               lo_in   = mid + IW'(1);
            end
         end
         ST_UP_READ: begin
            mem_rd_en   = in_store(sib_node);
            mem_rd_addr = sib_node[AW-1:0];
            sib_in      = in_store(sib_node);
         end
         ST_UP_WRITE: begin
            mem_wr_en   = in_store(parent_node);
            mem_wr_addr = parent_node[AW-1:0];
            mem_wr_data = parent_sum;
            cur_in      = in_store(parent_node) ? parent_sum : '0;
            node_in     = parent_node;
         end
         ST_QUERY: begin
            if (full) begin
               mem_rd_en   = in_store(node_ff);
               mem_rd_addr = node_ff[AW-1:0];
               if (sv_valid_ff) begin
                  node_in     = sv_node_ff;
                  lo_in       = sv_lo_ff;
                  hi_in       = sv_hi_ff;
                  sv_valid_in = 1'b0;
               end
            end else if (go_l && go_r) begin
               if (pos_ff <= lo_ff) begin
                  // left half covered: take it whole, walk right
                  mem_rd_en   = in_store(left_node);
                  mem_rd_addr = left_node[AW-1:0];
                  node_in     = right_node;
                  lo_in       = mid + IW'(1);
               end else if (rend_ff >= hi_ff) begin
                  mem_rd_en   = in_store(right_node);
                  mem_rd_addr = right_node[AW-1:0];
                  node_in     = left_node;
                  hi_in       = mid;
               end else begin
                  // split point: park the right walk
                  sv_node_in  = right_node;
                  sv_lo_in    = mid + IW'(1);
                  sv_hi_in    = hi_ff;
                  sv_valid_in = 1'b1;
                  node_in     = left_node;
                  hi_in       = mid;
               end
            end else if (go_l) begin
               node_in = left_node;
               hi_in   = mid;
            end else begin
               node_in = right_node;
               lo_in   = mid + IW'(1);
            end
            pend_in = mem_rd_en;
         end
         ST_DRAIN: begin
         end
         ST_RESULT: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
      if (clear_start) clr_cnt_in = '0;
   end

   assign res.range_sum   = signed'(VALUE_W'(acc_ff));
   assign res.index_error = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_cnt_ff  <= '0;
         sv_valid_ff <= 1'b0;
         pend_ff     <= 1'b0;
         sib_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         sv_valid_ff <= sv_valid_in;
         pend_ff     <= pend_in;
         sib_ff      <= sib_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      sv_node_ff <= sv_node_in;
      sv_lo_ff   <= sv_lo_in;
      sv_hi_ff   <= sv_hi_in;
      pos_ff     <= pos_in;
      rend_ff    <= rend_in;
      value_ff   <= value_in;
      cur_ff     <= cur_in;
      acc_ff     <= acc_in;
      err_ff     <= err_in;
   end

   // no same-entry read and write in one cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en && mem_wr_addr == mem_rd_addr))
      else $error("node store read and write hit the same entry");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DESCEND || state_ff == ST_QUERY) |-> lo_ff <= hi_ff)
      else $error("walk node range inverted");

   a_no_lost_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESULT |-> !pend_ff && !sv_valid_ff)
      else $error("result shown with a read or parked walk outstanding");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clear_start |=> !req.ready)
      else $error("command taken during clearing sweep");

   a_sib_after_read: assert property (@(posedge clock) disable iff (reset)
      sib_ff |-> $past(state_ff) == ST_UP_READ)
      else $error("sibling data flagged without a read");

endmodule

// ===== rtl/sum_segment_tree_core.sv =====
// ----------------------------------------------------------------------------
// sum_segment_tree_core
// Segment tree of wrapping sums with point write and range-sum query.
//
// Commands arrive on req_ch (valid/ready). cmd 0 writes value at position;
// cmd 1 returns the sum over [position, range_end]. Each command yields one
// result transaction on rsp_ch: range_sum (0 for writes and empty ranges)
// and index_error for indices outside the elements in use.
// csr_wr_en/csr_wr_data load element_count; every load clears the store.
// One command is in the walker at a time. A write walks down to the leaf,
// then rebuilds each ancestor in two states, ST_UP_READ (sibling read) and
// ST_UP_WRITE (parent write), as the single node-store read port is
// registered; a query walks the covering nodes and then waits in ST_DRAIN
// for its last read before the result.
// The result waits in an output register: a stalled receiver holds it while
// the walker takes the next command, whose result then waits in ST_RESULT.
// After reset, and after each element_count write, a clearing sweep over all
// NODE_COUNT entries zeroes the store; req_ch.ready stays low meanwhile.
// ----------------------------------------------------------------------------
module sum_segment_tree_core
   import sst_pkg::*;
#(
   parameter int MAX_ELEMENTS = 16,
   parameter int NODE_COUNT   = 64,
   parameter int DATA_WIDTH   = 32
) (
   input  logic               clock,
   input  logic               reset,
   sst_req_if.sink            req_ch,
   sst_rsp_if.source          rsp_ch,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   localparam int IW_RAW = $clog2(MAX_ELEMENTS) + 1;
   localparam int IW     = (IW_RAW > COUNT_W) ? IW_RAW : COUNT_W;
   localparam int NW_T   = $clog2(4 * MAX_ELEMENTS);
   localparam int NW_S   = $clog2(NODE_COUNT) + 1;
   localparam int NW     = (NW_T > NW_S) ? NW_T : NW_S;
   localparam int AW     = $clog2(NODE_COUNT);

   logic [COUNT_W-1:0]    element_count_ff, element_count_in;
   logic [IW-1:0]         count_ext, used_count;
   logic                  res_valid, res_ready;
   sst_rsp_type           res;
   logic                  rsp_valid_ff, rsp_valid_in;
   sst_rsp_type           rsp_data_ff, rsp_data_in;
   logic                  mem_wr_en, mem_rd_en;
   logic [AW-1:0]         mem_wr_addr, mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data, mem_rd_data;

   assign element_count_in = csr_wr_en ? csr_wr_data : element_count_ff;
   assign count_ext        = IW'(element_count_ff);

   always_comb begin
      if (element_count_ff == '0) begin
         used_count = IW'(1);
      end else if (count_ext > IW'(MAX_ELEMENTS)) begin
         used_count = IW'(MAX_ELEMENTS);
      end else begin
         used_count = count_ext;
      end
   end

   sst_engine #(
      .NODE_COUNT   (NODE_COUNT),
      .DATA_WIDTH   (DATA_WIDTH),
      .IW           (IW),
      .NW           (NW),
      .AW           (AW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .clear_start (csr_wr_en),
      .used_count  (used_count),
      .req         (req_ch),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   sst_node_ram #(
      .DEPTH (NODE_COUNT),
      .WIDTH (DATA_WIDTH),
      .AW    (AW)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.range_sum   = rsp_data_ff.range_sum;
   assign rsp_ch.index_error = rsp_data_ff.index_error;

   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= ELEMENT_COUNT_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         element_count_ff <= element_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
